FILE: design/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: design/dmdc_pkg.sv
package dmdc_pkg;

  localparam int ENTRIES     = 1024;
  localparam int HANDLE_BITS = 32;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int ADDR_W      = 64;
  localparam int HANDLE_W    = 32;
  localparam int CNT_W       = 11;
  localparam int SHIFT_W     = 2;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int ENTRY_W     = 1 + ADDR_W + HANDLE_BITS;

  localparam logic [2:0] MODE_LOOKUP    = 3'd0;
  localparam logic [2:0] MODE_FILL      = 3'd1;
  localparam logic [2:0] MODE_INV_ONE   = 3'd2;
  localparam logic [2:0] MODE_INV_RANGE = 3'd3;
  localparam logic [2:0] MODE_INV_ALL   = 3'd4;

  localparam logic [PADDR_W-3:0] REG_ADDRESS_SHIFT = '0;

  typedef struct packed {
    logic [2:0]          mode;
    logic [ADDR_W-1:0]   address;
    logic [ADDR_W-1:0]   range_end;
    logic [HANDLE_W-1:0] fill_handle;
  } in_word_t;

  typedef struct packed {
    logic                hit;
    logic [HANDLE_W-1:0] found_handle;
    logic                evicted_valid;
    logic [HANDLE_W-1:0] evicted_handle;
    logic [CNT_W-1:0]    invalidated_count;
  } out_word_t;

  typedef struct packed {
    logic                   valid;
    logic [ADDR_W-1:0]      tag;
    logic [HANDLE_BITS-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

endpackage

FILE: design/dmdc_ram.sv
module dmdc_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 97
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: design/dmdc_apb.sv
module dmdc_apb (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dmdc_pkg::PADDR_W-1:0]  paddr,
  input  logic [dmdc_pkg::PDATA_W-1:0]  pwdata,
  output logic [dmdc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output logic [dmdc_pkg::SHIFT_W-1:0]  address_shift
);

  logic                         sel_shift;
  logic [dmdc_pkg::SHIFT_W-1:0] address_shift_r;
  logic [dmdc_pkg::SHIFT_W-1:0] address_shift_nxt;

  assign sel_shift = (paddr[dmdc_pkg::PADDR_W-1:2] == dmdc_pkg::REG_ADDRESS_SHIFT);

  always_comb begin
    address_shift_nxt = address_shift_r;
    if (psel && penable && pwrite && sel_shift) begin
      address_shift_nxt = pwdata[dmdc_pkg::SHIFT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      address_shift_r <= '0;
    end else begin
      address_shift_r <= address_shift_nxt;
    end
  end

  // reads outside the register list return zero
  assign prdata = sel_shift ?
                  {{(dmdc_pkg::PDATA_W - dmdc_pkg::SHIFT_W){1'b0}}, address_shift_r} : '0;
  assign pready = 1'b1;
  assign address_shift = address_shift_r;

endmodule

FILE: design/dmdc_ctrl.sv
module dmdc_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [dmdc_pkg::SHIFT_W-1:0] address_shift,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  dmdc_pkg::in_word_t           in_word,
  output logic                         out_valid,
  input  logic                         out_ready,
  output dmdc_pkg::out_word_t          out_word,
  output dmdc_pkg::ram_req_t           ram_req,
  input  dmdc_pkg::entry_t             ram_rdata
);

  typedef enum logic [1:0] {ST_CLEAR, ST_RUN, ST_WALK, ST_DONE} state_t;

  state_t                         state_r, state_nxt;
  logic [dmdc_pkg::IDX_W:0]       cnt_r, cnt_nxt;
  logic                           wk_pend_r, wk_pend_nxt;
  logic [dmdc_pkg::IDX_W-1:0]     wk_idx_r, wk_idx_nxt;
  logic [dmdc_pkg::CNT_W-1:0]     inv_cnt_r, inv_cnt_nxt;
  logic                           s1_valid_r, s1_valid_nxt;
  dmdc_pkg::in_word_t             s1_word_r, s1_word_nxt;
  logic [dmdc_pkg::IDX_W-1:0]     s1_idx_r, s1_idx_nxt;
  logic                           s1_have_r, s1_have_nxt;
  dmdc_pkg::entry_t               s1_ent_r, s1_ent_nxt;
  logic                           out_valid_r, out_valid_nxt;
  dmdc_pkg::out_word_t            out_word_r, out_word_nxt;

  logic [dmdc_pkg::IDX_W-1:0]     in_idx;
  logic                           out_free;
  logic                           s1_bulk;
  logic                           s1_go;
  logic                           in_fire;
  dmdc_pkg::entry_t               eff;
  logic                           tag_hit;
  dmdc_pkg::out_word_t            res;
  logic                           s1_we;
  dmdc_pkg::entry_t               s1_wdata;
  logic [3:0]                     step_m;
  logic                           wk_match;
  dmdc_pkg::entry_t               cleared;

  assign in_idx   = dmdc_pkg::IDX_W'(in_word.address >> address_shift);
  assign out_free = !out_valid_r || out_ready;
  assign s1_bulk  = s1_valid_r && ((s1_word_r.mode == dmdc_pkg::MODE_INV_RANGE) ||
                                   (s1_word_r.mode == dmdc_pkg::MODE_INV_ALL));
  assign s1_go    = s1_valid_r && !s1_bulk && out_free && (state_r == ST_RUN);
  assign in_ready = (state_r == ST_RUN) && (!s1_valid_r || s1_go);
  assign in_fire  = in_valid && in_ready;

  // entry as seen by the item in flight: forwarded or held copy, else fresh read
  assign eff     = s1_have_r ? s1_ent_r : ram_rdata;
  assign tag_hit = eff.valid && (eff.tag == s1_word_r.address);

  always_comb begin
    res      = '0;
    s1_we    = 1'b0;
    s1_wdata = eff;
    case (s1_word_r.mode)
      dmdc_pkg::MODE_LOOKUP: begin
        if (tag_hit) begin
          res.hit          = 1'b1;
          res.found_handle = dmdc_pkg::HANDLE_W'(eff.handle);
        end
      end
      dmdc_pkg::MODE_FILL: begin
        if (eff.valid) begin
          res.evicted_valid  = 1'b1;
          res.evicted_handle = dmdc_pkg::HANDLE_W'(eff.handle);
        end
        s1_we           = 1'b1;
        s1_wdata.valid  = 1'b1;
        s1_wdata.tag    = s1_word_r.address;
        s1_wdata.handle = dmdc_pkg::HANDLE_BITS'(s1_word_r.fill_handle);
      end
      dmdc_pkg::MODE_INV_ONE: begin
        if (tag_hit) begin
          res.evicted_valid  = 1'b1;
          res.evicted_handle = dmdc_pkg::HANDLE_W'(eff.handle);
          s1_we              = 1'b1;
          s1_wdata.valid     = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // range step: tag and start must agree in the low address_shift bits
  assign step_m = (4'd1 << address_shift) - 4'd1;

  always_comb begin
    wk_match = ram_rdata.valid;
    if (s1_word_r.mode == dmdc_pkg::MODE_INV_RANGE) begin
      wk_match = ram_rdata.valid &&
                 (ram_rdata.tag >= s1_word_r.address) &&
                 (ram_rdata.tag < s1_word_r.range_end) &&
                 (((ram_rdata.tag[3:0] ^ s1_word_r.address[3:0]) & step_m) == 4'd0);
    end
    cleared       = ram_rdata;
    cleared.valid = 1'b0;
  end

  always_comb begin
    ram_req.raddr = in_idx;
    ram_req.we    = 1'b0;
    ram_req.waddr = s1_idx_r;
    ram_req.wdata = s1_wdata;
    case (state_r)
      ST_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cnt_r[dmdc_pkg::IDX_W-1:0];
        ram_req.wdata = '0;
      end
      ST_RUN: begin
        ram_req.we = s1_go && s1_we;
      end
      ST_WALK: begin
        ram_req.raddr = cnt_r[dmdc_pkg::IDX_W-1:0];
        ram_req.we    = wk_pend_r && wk_match;
        ram_req.waddr = wk_idx_r;
        ram_req.wdata = cleared;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    wk_pend_nxt   = wk_pend_r;
    wk_idx_nxt    = wk_idx_r;
    inv_cnt_nxt   = inv_cnt_r;
    s1_valid_nxt  = s1_valid_r;
    s1_word_nxt   = s1_word_r;
    s1_idx_nxt    = s1_idx_r;
    s1_have_nxt   = s1_have_r;
    s1_ent_nxt    = s1_ent_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[dmdc_pkg::IDX_W-1:0] == dmdc_pkg::IDX_W'(dmdc_pkg::ENTRIES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (s1_go) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = res;
          s1_valid_nxt  = 1'b0;
        end else if (s1_valid_r && !s1_have_r && !s1_bulk) begin
          // hold the read data while the output is stalled
          s1_have_nxt = 1'b1;
          s1_ent_nxt  = ram_rdata;
        end
        if (s1_bulk) begin
          cnt_nxt     = '0;
          wk_pend_nxt = 1'b0;
          inv_cnt_nxt = '0;
          state_nxt   = ST_WALK;
        end
        if (in_fire) begin
          s1_valid_nxt = 1'b1;
          s1_word_nxt  = in_word;
          s1_idx_nxt   = in_idx;
          // forward a write landing on the same entry in this cycle
          s1_have_nxt  = ram_req.we && (ram_req.waddr == in_idx);
          s1_ent_nxt   = ram_req.wdata;
        end
      end
      ST_WALK: begin
        wk_pend_nxt = !cnt_r[dmdc_pkg::IDX_W];
        wk_idx_nxt  = cnt_r[dmdc_pkg::IDX_W-1:0];
        if (!cnt_r[dmdc_pkg::IDX_W]) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (wk_pend_r && wk_match && (inv_cnt_r != '1)) begin
          inv_cnt_nxt = inv_cnt_r + 1'b1;
        end
        if (cnt_r[dmdc_pkg::IDX_W] && !wk_pend_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt                  = 1'b1;
          out_word_nxt                   = '0;
          out_word_nxt.invalidated_count = inv_cnt_r;
          s1_valid_nxt                   = 1'b0;
          state_nxt                      = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      wk_pend_r   <= 1'b0;
      s1_valid_r  <= 1'b0;
      s1_have_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      wk_pend_r   <= wk_pend_nxt;
      s1_valid_r  <= s1_valid_nxt;
      s1_have_r   <= s1_have_nxt;
      out_valid_r <= out_valid_nxt;
    end
    wk_idx_r   <= wk_idx_nxt;
    inv_cnt_r  <= inv_cnt_nxt;
    s1_word_r  <= s1_word_nxt;
    s1_idx_r   <= s1_idx_nxt;
    s1_ent_r   <= s1_ent_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

FILE: design/direct_mapped_decode_cache_top.sv
// Direct-mapped cache of decoded-instruction handles, 1024 entries, each holding a
// valid bit, the full 64-bit address as tag and a 32-bit handle, all in one
// synchronous RAM word. An address picks entry (address >> address_shift) mod 1024.
// Lookup, fill and single invalidate take one word per cycle while the result side is
// ready: the RAM is read as the word is taken into the stage register, and the result
// is formed from the read data and registered onto the result channel; a write to the
// entry a following word reads is forwarded. Range and full invalidate walk every
// entry through the RAM read port, one per cycle, and their count is registered onto
// the result channel once the walk ends and the result side is free; no new word is
// taken meanwhile. After reset a clearing pass marks every entry invalid, and
// in_ready stays low until it ends; configuration writes are taken throughout.
// Write address_shift only while the block is idle.
module direct_mapped_decode_cache_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // item channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  dmdc_pkg::in_word_t            in_word,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output dmdc_pkg::out_word_t           out_word,
  // configuration port
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [dmdc_pkg::PADDR_W-1:0]  cfg_paddr,
  input  logic [dmdc_pkg::PDATA_W-1:0]  cfg_pwdata,
  output logic [dmdc_pkg::PDATA_W-1:0]  cfg_prdata,
  output logic                          cfg_pready
);

  logic [dmdc_pkg::SHIFT_W-1:0] address_shift;
  dmdc_pkg::ram_req_t           ram_req;
  logic [dmdc_pkg::ENTRY_W-1:0] ram_rvec;
  dmdc_pkg::entry_t             ram_rdata;

  // register file: address_shift only
  dmdc_apb u_apb (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (cfg_psel),
    .penable       (cfg_penable),
    .pwrite        (cfg_pwrite),
    .paddr         (cfg_paddr),
    .pwdata        (cfg_pwdata),
    .prdata        (cfg_prdata),
    .pready        (cfg_pready),
    .address_shift (address_shift)
  );

  // sequencer: read-modify-write of single words, table walk, clearing pass
  dmdc_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .address_shift (address_shift),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_word      (out_word),
    .ram_req       (ram_req),
    .ram_rdata     (ram_rdata)
  );

  assign ram_rdata = ram_rvec;

  // entry store: one write port, one registered read port
  dmdc_ram #(
    .DEPTH (dmdc_pkg::ENTRIES),
    .WIDTH (dmdc_pkg::ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rvec)
  );

endmodule

FILE: design/dmdc_checker.sv
`include "assert_macros.svh"

module dmdc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input dmdc_pkg::out_word_t out_word
);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word))
  `ASSERT_IMP(a_one_kind, clk, rst_n, out_valid, !(out_word.hit && out_word.evicted_valid))
  `ASSERT_IMP(a_found_zero, clk, rst_n, out_valid && !out_word.hit, out_word.found_handle == '0)
  `ASSERT_IMP(a_evict_zero, clk, rst_n, out_valid && !out_word.evicted_valid, out_word.evicted_handle == '0)
  `ASSERT_IMP(a_count_alone, clk, rst_n, out_valid && (out_word.invalidated_count != '0), !out_word.hit && !out_word.evicted_valid)

endmodule

bind direct_mapped_decode_cache_top dmdc_checker u_dmdc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

FILE: tb/decode_cache_checker.sv
`timescale 1ns / 100ps

module decode_cache_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  dmdc_pkg::in_word_t           in_word,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  dmdc_pkg::out_word_t          out_word,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [dmdc_pkg::PADDR_W-1:0] paddr,
  input  logic [dmdc_pkg::PDATA_W-1:0] pwdata,
  input  logic [dmdc_pkg::PDATA_W-1:0] prdata,
  output int unsigned                  error_count,
  output int unsigned                  words_outstanding
);
  import dmdc_pkg::*;

  localparam logic [HANDLE_W-1:0] HANDLE_MASK =
    (HANDLE_BITS >= HANDLE_W) ? '1 : ((HANDLE_W'(1) << HANDLE_BITS) - 1'b1);

  // Shadow copy of the tag store and the shift register.
  logic                slot_valid [ENTRIES];
  logic [ADDR_W-1:0]   slot_tag [ENTRIES];
  logic [HANDLE_W-1:0] slot_handle [ENTRIES];
  logic [SHIFT_W-1:0]  shift_now;

  out_word_t   predicted_responses [$];
  out_word_t   expected_word;
  int unsigned errors;

  function automatic logic [IDX_W-1:0] slot_index(input logic [ADDR_W-1:0] a);
    return IDX_W'(a >> shift_now);
  endfunction

  // Apply one word to the shadow store and return the response it must give.
  function automatic out_word_t cache_access(input in_word_t w);
    out_word_t         r;
    logic [IDX_W-1:0]  s;
    logic [ADDR_W-1:0] step_mask;
    logic [CNT_W-1:0]  dropped;
    r = '0;
    dropped = '0;
    s = slot_index(w.address);
    step_mask = (ADDR_W'(1) << shift_now) - 1'b1;
    case (w.mode)
      MODE_LOOKUP: begin
        if (slot_valid[s] && slot_tag[s] == w.address) begin
          r.hit = 1'b1;
          r.found_handle = slot_handle[s];
        end
      end
      MODE_FILL: begin
        if (slot_valid[s]) begin
          r.evicted_valid = 1'b1;
          r.evicted_handle = slot_handle[s];
        end
        slot_valid[s] = 1'b1;
        slot_tag[s] = w.address;
        slot_handle[s] = w.fill_handle & HANDLE_MASK;
      end
      MODE_INV_ONE: begin
        if (slot_valid[s] && slot_tag[s] == w.address) begin
          r.evicted_valid = 1'b1;
          r.evicted_handle = slot_handle[s];
          slot_valid[s] = 1'b0;
        end
      end
      MODE_INV_RANGE: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_valid[i] && slot_tag[i] >= w.address && slot_tag[i] < w.range_end &&
              ((slot_tag[i] - w.address) & step_mask) == '0) begin
            slot_valid[i] = 1'b0;
            if (dropped != '1) dropped = dropped + 1'b1;
          end
        end
        r.invalidated_count = dropped;
      end
      MODE_INV_ALL: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_valid[i]) begin
            slot_valid[i] = 1'b0;
            if (dropped != '1) dropped = dropped + 1'b1;
          end
        end
        r.invalidated_count = dropped;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) slot_valid[i] = 1'b0;
      shift_now = '0;
      predicted_responses.delete();
      errors = 0;
    end else begin
      if (psel && penable && pready && paddr[PADDR_W-1:2] == REG_ADDRESS_SHIFT) begin
        if (pwrite) begin
          shift_now = pwdata[SHIFT_W-1:0];
        end else if (prdata !== PDATA_W'(shift_now)) begin
          errors++;
          if (errors <= 10)
            $display("%0t: address_shift read back %h, expected %h", $time, prdata,
                     PDATA_W'(shift_now));
        end
      end
      // Retire before predicting: a response never belongs to the word taken at the same edge.
      if (out_valid === 1'b1 && out_ready) begin
        if (predicted_responses.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: response with nothing outstanding: %p", $time, out_word);
        end else begin
          expected_word = predicted_responses.pop_front();
          if (out_word.hit !== expected_word.hit ||
              out_word.found_handle !== expected_word.found_handle ||
              out_word.evicted_valid !== expected_word.evicted_valid ||
              out_word.evicted_handle !== expected_word.evicted_handle ||
              out_word.invalidated_count !== expected_word.invalidated_count) begin
            errors++;
            if (errors <= 10)
              $display("%0t: response mismatch\n  expected hit=%b found=%h evicted=%b/%h count=%0d",
                       $time, expected_word.hit, expected_word.found_handle,
                       expected_word.evicted_valid, expected_word.evicted_handle,
                       expected_word.invalidated_count,
                       "\n  actual   hit=%b found=%h evicted=%b/%h count=%0d",
                       out_word.hit, out_word.found_handle, out_word.evicted_valid,
                       out_word.evicted_handle, out_word.invalidated_count);
          end
        end
      end
      if (in_valid && in_ready) predicted_responses.push_back(cache_access(in_word));
    end
    error_count <= errors;
    words_outstanding <= predicted_responses.size();
  end

endmodule

FILE: tb/direct_mapped_decode_cache_top_test.sv
`timescale 1ns / 100ps

module direct_mapped_decode_cache_top_test;
  import dmdc_pkg::*;

  // Codes above invalidate-all are spare and must leave the cache untouched.
  localparam logic [2:0]          MODE_LAST_USED   = MODE_INV_ALL;
  localparam logic [ADDR_W-1:0]   TOP_ADDRESS      = '1;
  localparam int unsigned         LONG_HOLD_CYCLES = 400;
  localparam int unsigned         HOLD_AFTER_WORDS = 60;
  localparam int unsigned         PHASE_WORDS      = 140;
  localparam int unsigned         SWEEP_WORDS      = 256;
  localparam int unsigned         POOL_DEPTH       = 48;
  localparam int unsigned         SETTLE_CYCLES    = 16;
  // Shift used by each random phase, index 0 first: 3, 1, 2, 0, 3.
  localparam logic [4:0][SHIFT_W-1:0] SHIFT_PLAN = {2'd3, 2'd0, 2'd2, 2'd1, 2'd3};

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_word_t            in_word;
  logic                out_valid;
  logic                out_ready;
  out_word_t           out_word;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  int unsigned         error_count;
  int unsigned         words_outstanding;

  // Stimulus-side bookkeeping: current shift, addresses filled lately, words sent.
  logic [SHIFT_W-1:0]  cur_shift;
  logic [ADDR_W-1:0]   known_addrs [$];
  int unsigned         words_sent;
  int unsigned         steady_left;

  direct_mapped_decode_cache_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_word    (out_word),
    .cfg_psel    (psel),
    .cfg_penable (penable),
    .cfg_pwrite  (pwrite),
    .cfg_paddr   (paddr),
    .cfg_pwdata  (pwdata),
    .cfg_prdata  (prdata),
    .cfg_pready  (pready)
  );

  // The checker watches all three ports, predicts every response and counts failures.
  decode_cache_checker result_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_word           (in_word),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_word          (out_word),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .pready            (pready),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .error_count       (error_count),
    .words_outstanding (words_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop: the slowest legal run is well under a fifth of this.
  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(12, 60);
  endfunction

  // Address in one of a few regions, with enough spread that distinct tags
  // alias onto the same entry; occasionally off the step grid.
  function automatic logic [ADDR_W-1:0] fresh_address();
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] a;
    case ($urandom_range(0, 3))
      0:       base = '0;
      1:       base = 64'h0000_0000_8000_0000;
      2:       base = 64'hFFFF_FFFF_FFFF_0000;
      default: base = {$urandom(), $urandom()} & ~ADDR_W'(16'hFFFF);
    endcase
    a = base + (ADDR_W'($urandom_range(0, 4095)) << cur_shift);
    if ($urandom_range(0, 9) == 0) a = a + ADDR_W'($urandom_range(1, 7));
    return a;
  endfunction

  function automatic logic [ADDR_W-1:0] known_address();
    if (known_addrs.size() == 0) return fresh_address();
    return known_addrs[$urandom_range(0, known_addrs.size() - 1)];
  endfunction

  // Fields a mode does not use carry random values.
  function automatic in_word_t op_word(input logic [2:0] mode, input logic [ADDR_W-1:0] addr);
    in_word_t w;
    w.mode = mode;
    w.address = addr;
    w.range_end = {$urandom(), $urandom()};
    w.fill_handle = $urandom();
    return w;
  endfunction

  // Offer one word and hold it until taken. Drop valid only for an idle gap,
  // so back-to-back words keep it high without a second assignment.
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    if (steady_left > 0) begin
      steady_left--;
      gap = 0;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 31) == 0) steady_left = $urandom_range(20, 80);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic do_lookup(input logic [ADDR_W-1:0] a);
    send_word(op_word(MODE_LOOKUP, a));
  endtask

  task automatic do_fill(input logic [ADDR_W-1:0] a, input logic [HANDLE_W-1:0] handle);
    in_word_t w;
    w = op_word(MODE_FILL, a);
    w.fill_handle = handle;
    send_word(w);
    known_addrs.push_back(a);
    if (known_addrs.size() > POOL_DEPTH) void'(known_addrs.pop_front());
  endtask

  task automatic do_drop(input logic [ADDR_W-1:0] a);
    send_word(op_word(MODE_INV_ONE, a));
  endtask

  task automatic do_range(input logic [ADDR_W-1:0] start, input logic [ADDR_W-1:0] stop);
    in_word_t w;
    w = op_word(MODE_INV_RANGE, start);
    w.range_end = stop;
    send_word(w);
  endtask

  task automatic do_flush();
    send_word(op_word(MODE_INV_ALL, {$urandom(), $urandom()}));
  endtask

  task automatic do_spare();
    send_word(op_word(MODE_LAST_USED + 3'($urandom_range(1, 3)), {$urandom(), $urandom()}));
  endtask

  // Drop valid and wait until every response has come back. The count is
  // registered, so advance before the first look.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_outstanding != 0);
  endtask

  // Write the shift register, then read it back for the checker.
  task automatic write_shift(input logic [SHIFT_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_ADDRESS_SHIFT, 2'b00};
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    cur_shift = value;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly the fetch path's own traffic (lookup, miss, fill, hit) on a small
  // set of live addresses; aliasing tags, single drops, range and full
  // flushes, fully random words and spare codes make up the rest.
  task automatic random_phase(input int unsigned count);
    int unsigned       target;
    int unsigned       r;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
    logic [ADDR_W-1:0] alias_step;
    target = words_sent + count;
    alias_step = ADDR_W'(ENTRIES) << cur_shift;
    while (words_sent < target) begin
      r = $urandom_range(0, 99);
      a = known_address();
      if (r < 28) begin
        do_lookup(a);
      end else if (r < 44) begin
        a = fresh_address();
        do_lookup(a);
        do_fill(a, $urandom());
        if ($urandom_range(0, 1)) do_lookup(a);
      end else if (r < 56) begin
        do_fill($urandom_range(0, 1) ? a : a + alias_step, $urandom());
      end else if (r < 68) begin
        do_drop(a);
        if ($urandom_range(0, 1)) do_lookup(a);
      end else if (r < 76) begin
        // same entry, different tag: must miss and must not drop
        b = a + alias_step;
        if ($urandom_range(0, 1)) do_drop(b);
        else do_lookup(b);
      end else if (r < 83) begin
        a = a - (ADDR_W'($urandom_range(0, 32)) << cur_shift);
        if ($urandom_range(0, 3) == 0) a = a + ADDR_W'($urandom_range(1, 7));
        case ($urandom_range(0, 9))
          0:       b = a - ADDR_W'($urandom_range(0, 16));
          1:       b = TOP_ADDRESS;
          2:       b = {$urandom(), $urandom()};
          default: b = a + (ADDR_W'($urandom_range(1, 600)) << cur_shift);
        endcase
        do_range(a, b);
      end else if (r < 84) begin
        do_flush();
      end else if (r < 88) begin
        do_fill({$urandom(), $urandom()}, $urandom());
      end else if (r < 92) begin
        send_word(op_word(3'($urandom_range(0, 2)), {$urandom(), $urandom()}));
      end else if (r < 95) begin
        do_spare();
      end else begin
        // near miss: right entry region, low bits disturbed
        do_lookup(a ^ ADDR_W'($urandom_range(1, 7)));
      end
    end
  endtask

  // Result side: random stalls, long ready runs now and then, and one long
  // hold-off while the sender keeps offering, so the pipe fills and in_ready drops.
  initial begin
    int unsigned words_taken;
    int unsigned run;
    bit          held_long;
    words_taken = 0;
    held_long = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!held_long && words_taken >= HOLD_AFTER_WORDS) begin
        held_long = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else begin
        run = pick_gap();
        if (run != 0) begin
          out_ready <= 1'b0;
          repeat (run) @(posedge clk);
        end
        out_ready <= 1'b1;
        run = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 150) : $urandom_range(1, 12);
        repeat (run) begin
          @(posedge clk);
          if (out_valid && out_ready) words_taken++;
        end
      end
    end
  end

  initial begin
    logic [ADDR_W-1:0] base;
    rst_n   <= 1'b0;
    in_valid <= 1'b0;
    in_word <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    cur_shift = '0;
    words_sent = 0;
    steady_left = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words at reset shift. The block clears its store after reset;
    // the first word simply waits for in_ready.
    do_lookup('0);                          // empty cache misses
    do_drop('0);                            // drop of an invalid entry
    do_fill('0, '1);
    do_lookup('0);                          // hit, all-ones handle
    do_lookup(ADDR_W'(ENTRIES));            // same entry, other tag
    do_drop(ADDR_W'(ENTRIES));              // tag mismatch: nothing dropped
    do_fill(ADDR_W'(ENTRIES), '0);          // evicts the all-ones handle
    do_lookup(ADDR_W'(ENTRIES));
    do_drop(ADDR_W'(ENTRIES));              // evicts the zero handle
    do_lookup(ADDR_W'(ENTRIES));
    do_fill(TOP_ADDRESS, 32'hA5A5_A5A5);    // highest address, last entry
    do_lookup(TOP_ADDRESS);
    do_fill(ADDR_W'(5), 32'h0000_0001);
    do_fill(ADDR_W'(6), 32'h0000_0002);
    do_fill(ADDR_W'(7), 32'h0000_0003);
    do_range(ADDR_W'(5), ADDR_W'(7));       // end is exclusive: two go
    do_range(ADDR_W'(100), ADDR_W'(50));    // reversed range clears nothing
    do_range(ADDR_W'(7), ADDR_W'(7));       // empty range
    do_range('0, TOP_ADDRESS);              // top address itself lies outside
    do_lookup(TOP_ADDRESS);
    do_spare();
    do_spare();
    do_spare();
    do_flush();
    do_lookup(TOP_ADDRESS);

    for (int p = 0; p < 5; p++) begin
      drain();
      write_shift(SHIFT_PLAN[p]);
      if (p == 0) begin
        // Fill a block of consecutive entries, then drop the lot with one range.
        base = {$urandom(), $urandom()} & ~ADDR_W'(16'hFFFF);
        for (int k = 0; k < SWEEP_WORDS; k++)
          do_fill(base + (ADDR_W'(k) << cur_shift), $urandom());
        do_range(base, base + (ADDR_W'(SWEEP_WORDS) << cur_shift));
      end
      random_phase(PHASE_WORDS);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && words_outstanding == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
